[sv/dap_pkg.sv]
// Package for the decimal amount parser: payload structs, status and
// character class codes, register indexes and the power-of-ten table.
// No dependencies.
package dap_pkg;

  // Status codes of a result item
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_DECIMALS = 3'd2,
    ST_INVALID  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_SUPPLY   = 3'd5
  } status_e;

  // Character classes seen by the accumulator
  typedef enum logic [1:0] {
    CC_DIGIT = 2'd0,
    CC_DOT   = 2'd1,
    CC_OTHER = 2'd2
  } char_cls_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_DECIMALS   = 2'd0;
  localparam logic [1:0] CFG_ATOM_SCALE = 2'd1;
  localparam logic [1:0] CFG_SUPPLY     = 2'd2;

  localparam logic [4:0]  DECIMALS_RST   = 5'd8;
  localparam logic [63:0] ATOM_SCALE_RST = 64'd100000000;
  localparam logic [63:0] SUPPLY_RST     = 64'd2100000000000000;

  // Largest whole part that still takes another digit (2^64-1 over ten)
  localparam logic [63:0] WHOLE_LIM  = 64'd1844674407370955161;
  localparam logic [3:0]  WHOLE_LAST = 4'd5;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [7:0]  CH_DOT     = 8'h2e;
  localparam logic [4:0]  FLEN_SAT   = 5'd31;

  // Input item
  typedef struct packed {
    logic       has_char;
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_e     status;
    logic [63:0] atoms;
  } result_t;

  // Classified item between front and back
  typedef struct packed {
    logic       has_char;
    char_cls_e  cls;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  // Ten to the power idx, idx 0..19
  function automatic logic [63:0] pow_ten(input logic [4:0] idx);
    logic [63:0] r;
    case (idx)
      5'd0:  r = 64'd1;
      5'd1:  r = 64'd10;
      5'd2:  r = 64'd100;
      5'd3:  r = 64'd1000;
      5'd4:  r = 64'd10000;
      5'd5:  r = 64'd100000;
      5'd6:  r = 64'd1000000;
      5'd7:  r = 64'd10000000;
      5'd8:  r = 64'd100000000;
      5'd9:  r = 64'd1000000000;
      5'd10: r = 64'd10000000000;
      5'd11: r = 64'd100000000000;
      5'd12: r = 64'd1000000000000;
      5'd13: r = 64'd10000000000000;
      5'd14: r = 64'd100000000000000;
      5'd15: r = 64'd1000000000000000;
      5'd16: r = 64'd10000000000000000;
      5'd17: r = 64'd100000000000000000;
      5'd18: r = 64'd1000000000000000000;
      5'd19: r = 64'd10000000000000000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

endpackage

[sv/decimal_amount_parser.sv]
// Decimal amount parser, top level. Takes one character item per cycle
// while full is low. The result of an end-marked item passes the front
// register, item queue, accumulator, product stage and check stage.
// Throughput is one item per cycle while the result queue has room, set
// by the digit accumulator. Reset clears all parse state and queues and
// loads the register reset values; no clearing pass.
module decimal_amount_parser #(
  parameter int MAX_DECIMALS = 19,
  parameter int TOK_DEPTH    = 4,
  parameter int RES_DEPTH    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  dap_pkg::in_item_t item_i,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output dap_pkg::result_t  result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i
);

  localparam int TOK_W = $bits(dap_pkg::tok_t);
  localparam int RES_W = $bits(dap_pkg::result_t);

  logic [4:0]  decimals_q;
  logic [63:0] atom_scale_q, supply_q;

  logic             fr_vld, fr_rdy;
  dap_pkg::tok_t    fr_tok;
  logic             tq_full, tq_empty, bk_rdy;
  logic [TOK_W-1:0] tq_dout;
  logic             res_push, res_full;
  dap_pkg::result_t res_d;
  logic [RES_W-1:0] rq_dout;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimals_q   <= dap_pkg::DECIMALS_RST;
      atom_scale_q <= dap_pkg::ATOM_SCALE_RST;
      supply_q     <= dap_pkg::SUPPLY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dap_pkg::CFG_DECIMALS:   decimals_q   <= cfg_data_i[4:0];
        dap_pkg::CFG_ATOM_SCALE: atom_scale_q <= cfg_data_i;
        dap_pkg::CFG_SUPPLY:     supply_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dap_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .full_o    (full),
    .tok_vld_o (fr_vld),
    .tok_o     (fr_tok),
    .tok_rdy_i (fr_rdy)
  );

  assign fr_rdy = ~tq_full;

  // item queue between front and back
  dap_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (TOK_DEPTH)
  ) u_tok_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_vld),
    .data_i  (fr_tok),
    .full_o  (tq_full),
    .pop_i   (bk_rdy),
    .data_o  (tq_dout),
    .empty_o (tq_empty)
  );

  dap_back #(
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_vld_i    (~tq_empty),
    .tok_i        (dap_pkg::tok_t'(tq_dout)),
    .tok_rdy_o    (bk_rdy),
    .decimals_i   (decimals_q),
    .atom_scale_i (atom_scale_q),
    .supply_i     (supply_q),
    .res_push_o   (res_push),
    .res_o        (res_d),
    .res_full_i   (res_full)
  );

  // result queue
  dap_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (rq_dout),
    .empty_o (empty)
  );

  assign result_o = dap_pkg::result_t'(rq_dout);

endmodule

[sv/dap_fifo.sv]
// Small first-word-fall-through queue of packed words.
// No dependencies. DEPTH must be a power of two, at least 2.
module dap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wr_d  = push_ok ? wr_q + AW'(1) : wr_q;
    rd_d  = pop_ok ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[sv/dap_front.sv]
// Front of the parser: takes input items, classifies the character and
// drops items that carry neither a character nor an end mark. Uses dap_pkg.
module dap_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dap_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              tok_vld_o,
  output dap_pkg::tok_t     tok_o,
  input  logic              tok_rdy_i
);

  logic              vld_q, vld_d;
  dap_pkg::tok_t     tok_q, tok_d;
  logic              take;

  // stage holds one item; it is free when empty or draining this cycle
  assign full_o    = vld_q & ~tok_rdy_i;
  assign take      = push_i & ~full_o;
  assign tok_vld_o = vld_q;
  assign tok_o     = tok_q;

  // classify the byte
  always_comb begin
    tok_d.has_char = item_i.has_char;
    tok_d.last     = item_i.last;
    tok_d.digit    = item_i.char_code[3:0];
    if (item_i.char_code >= dap_pkg::CH_ZERO && item_i.char_code <= dap_pkg::CH_NINE) begin
      tok_d.cls = dap_pkg::CC_DIGIT;
    end else if (item_i.char_code == dap_pkg::CH_DOT) begin
      tok_d.cls = dap_pkg::CC_DOT;
    end else begin
      tok_d.cls = dap_pkg::CC_OTHER;
    end
  end

  // no-op items never enter the queue
  always_comb begin
    vld_d = vld_q & ~tok_rdy_i;
    if (take) begin
      vld_d = item_i.has_char | item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q <= tok_d;
    end
  end

endmodule

[sv/dap_back.sv]
// Back of the parser: digit accumulator and a three-stage finish pipeline
// (partial products, product assembly, checks). Uses dap_pkg.
module dap_back #(
  parameter int MAX_DECIMALS = 19
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_vld_i,
  input  dap_pkg::tok_t     tok_i,
  output logic              tok_rdy_o,
  input  logic [4:0]        decimals_i,
  input  logic [63:0]       atom_scale_i,
  input  logic [63:0]       supply_i,
  output logic              res_push_o,
  output dap_pkg::result_t  res_o,
  input  logic              res_full_i
);

  localparam logic [4:0] MAXD = 5'(MAX_DECIMALS);

  logic en;
  logic acc_go;

  // accumulator state
  logic [63:0] whole_q, whole_d, frac_q, frac_d;
  logic [4:0]  flen_q, flen_d;
  logic        dot_q, dot_d, any_q, any_d, inv_q, inv_d, ovf_q, ovf_d;

  // stage 1: finished parse
  logic        s1_vld_q;
  logic [63:0] s1_whole_q, s1_frac_q;
  logic [4:0]  s1_flen_q;
  logic        s1_any_q, s1_inv_q, s1_ovf_q;

  // stage 2: partial products
  logic             s2_vld_q;
  dap_pkg::status_e s2_st_q, s2_st_d;
  logic [63:0]      pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q, fp_ll_q;
  logic [31:0]      fp_lh_q, fp_hl_q;
  logic [4:0]       dec;
  logic [63:0]      pow;

  // stage 3: assembled values
  logic             s3_vld_q;
  dap_pkg::status_e s3_st_q;
  logic             s3_hinz_q, s3_hinz_d;
  logic [63:0]      s3_lo_q, s3_lo_d, s3_fval_q, s3_fval_d;
  logic [33:0]      mid;
  logic [64:0]      sum;

  // whole pipeline moves only when the result queue has room
  assign en        = ~res_full_i;
  assign tok_rdy_o = en;
  assign acc_go    = en & tok_vld_i;

  // next accumulator state for the current item
  always_comb begin
    whole_d = whole_q;
    frac_d  = frac_q;
    flen_d  = flen_q;
    dot_d   = dot_q;
    any_d   = any_q;
    inv_d   = inv_q;
    ovf_d   = ovf_q;
    if (tok_i.has_char) begin
      any_d = 1'b1;
      if (!dot_q) begin
        if (tok_i.cls == dap_pkg::CC_DOT) begin
          dot_d = 1'b1;
        end else if (tok_i.cls != dap_pkg::CC_DIGIT) begin
          inv_d = 1'b1;
        end else if (!ovf_q) begin
          if (whole_q > dap_pkg::WHOLE_LIM ||
              (whole_q == dap_pkg::WHOLE_LIM && tok_i.digit > dap_pkg::WHOLE_LAST)) begin
            ovf_d = 1'b1;
          end else begin
            whole_d = (whole_q << 3) + (whole_q << 1) + {60'd0, tok_i.digit};
          end
        end
      end else begin
        if (flen_q != dap_pkg::FLEN_SAT) begin
          flen_d = flen_q + 5'd1;
        end
        if (tok_i.cls != dap_pkg::CC_DIGIT) begin
          inv_d = 1'b1;
        end else if (flen_d <= MAXD) begin
          frac_d = (frac_q << 3) + (frac_q << 1) + {60'd0, tok_i.digit};
        end
      end
    end
  end

  // accumulator; an end mark hands the parse to stage 1 and clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q  <= '0;
      frac_q   <= '0;
      flen_q   <= '0;
      dot_q    <= 1'b0;
      any_q    <= 1'b0;
      inv_q    <= 1'b0;
      ovf_q    <= 1'b0;
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= tok_vld_i & tok_i.last;
      if (acc_go) begin
        if (tok_i.last) begin
          whole_q <= '0;
          frac_q  <= '0;
          flen_q  <= '0;
          dot_q   <= 1'b0;
          any_q   <= 1'b0;
          inv_q   <= 1'b0;
          ovf_q   <= 1'b0;
        end else begin
          whole_q <= whole_d;
          frac_q  <= frac_d;
          flen_q  <= flen_d;
          dot_q   <= dot_d;
          any_q   <= any_d;
          inv_q   <= inv_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_go && tok_i.last) begin
      s1_whole_q <= whole_d;
      s1_frac_q  <= frac_d;
      s1_flen_q  <= flen_d;
      s1_any_q   <= any_d;
      s1_inv_q   <= inv_d;
      s1_ovf_q   <= ovf_d;
    end
  end

  // stage 1 -> 2: early status and 32x32 partial products
  assign dec = (decimals_i > MAXD) ? MAXD : decimals_i;
  assign pow = dap_pkg::pow_ten(dec - s1_flen_q);

  always_comb begin
    if (!s1_any_q) begin
      s2_st_d = dap_pkg::ST_EMPTY;
    end else if (s1_flen_q > dec) begin
      s2_st_d = dap_pkg::ST_DECIMALS;
    end else if (s1_inv_q) begin
      s2_st_d = dap_pkg::ST_INVALID;
    end else if (s1_ovf_q) begin
      s2_st_d = dap_pkg::ST_OVERFLOW;
    end else begin
      s2_st_d = dap_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_vld_q) begin
      s2_st_q <= s2_st_d;
      pp_ll_q <= s1_whole_q[31:0]  * atom_scale_i[31:0];
      pp_lh_q <= s1_whole_q[31:0]  * atom_scale_i[63:32];
      pp_hl_q <= s1_whole_q[63:32] * atom_scale_i[31:0];
      pp_hh_q <= s1_whole_q[63:32] * atom_scale_i[63:32];
      fp_ll_q <= s1_frac_q[31:0] * pow[31:0];
      fp_lh_q <= 32'(s1_frac_q[31:0] * pow[63:32]);
      fp_hl_q <= 32'(s1_frac_q[63:32] * pow[31:0]);
    end
  end

  // stage 2 -> 3: low word of the whole product, high word only tested
  // for nonzero, padded fraction low word
  always_comb begin
    mid = {2'b00, pp_ll_q[63:32]} + {2'b00, pp_lh_q[31:0]} + {2'b00, pp_hl_q[31:0]};
    s3_lo_d   = {mid[31:0], pp_ll_q[31:0]};
    s3_hinz_d = (|pp_hh_q) | (|pp_lh_q[63:32]) | (|pp_hl_q[63:32]) | (|mid[33:32]);
    s3_fval_d = fp_ll_q + {fp_lh_q + fp_hl_q, 32'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_vld_q) begin
      s3_st_q   <= s2_st_q;
      s3_hinz_q <= s3_hinz_d;
      s3_lo_q   <= s3_lo_d;
      s3_fval_q <= s3_fval_d;
    end
  end

  // stage 3: supply and sum checks, result to the queue
  assign sum        = {1'b0, s3_lo_q} + {1'b0, s3_fval_q};
  assign res_push_o = en & s3_vld_q;

  always_comb begin
    res_o.atoms  = '0;
    res_o.status = s3_st_q;
    if (s3_st_q == dap_pkg::ST_OK) begin
      if (s3_hinz_q || s3_lo_q > supply_i) begin
        res_o.status = dap_pkg::ST_SUPPLY;
      end else if (sum[64]) begin
        res_o.status = dap_pkg::ST_OVERFLOW;
      end else if (sum[63:0] > supply_i) begin
        res_o.status = dap_pkg::ST_SUPPLY;
      end else begin
        res_o.atoms = sum[63:0];
      end
    end
  end

endmodule

[tb/tb_decimal_amount_parser.sv]
// Testbench for decimal_amount_parser: drives character items, predicts each
// amount result in a local model, and checks every popped result against it.
// Depends on dap_pkg and the decimal_amount_parser top level.
`timescale 1ns / 100ps

module tb_decimal_amount_parser;

  localparam int          CLK_HALF        = 4;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          SETTLE_CYCLES   = 10;
  localparam int          LONG_HOLD       = 200;
  localparam int          MAX_FRAC_DIGITS = 19;
  localparam logic [1:0]  CFG_SPARE       = 2'd3;
  localparam logic [63:0] ALL_ONES        = '1;

  // Clock, reset and block ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              push        = 1'b0;
  dap_pkg::in_item_t item_i      = '0;
  logic              full;
  logic              empty;
  logic              pop         = 1'b0;
  dap_pkg::result_t  result_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [63:0]       cfg_data_i  = '0;

  // Local copy of the registers
  logic [4:0]  cfg_decimals;
  logic [63:0] cfg_scale;
  logic [63:0] cfg_supply;

  // Local copy of the parse state
  logic [63:0] acc_whole;
  logic [63:0] acc_frac;
  logic [4:0]  acc_flen;
  bit          acc_dot;
  bit          acc_any;
  bit          acc_bad;
  bit          acc_ovf;

  dap_pkg::result_t expected_amounts[$];
  int          err_count   = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;

  // Stimulus knobs for the input side and the result side
  int          tx_gap_rate  = 0;
  int          noise_rate   = 0;
  bit          rx_stall_en  = 1'b0;
  bit          hold_request = 1'b0;

  decimal_amount_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .item_i      (item_i),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] r;
    r = 64'd1;
    repeat (n) r = r * 64'd10;
    return r;
  endfunction

  task automatic clear_amount();
    acc_whole = '0;
    acc_frac  = '0;
    acc_flen  = '0;
    acc_dot   = 1'b0;
    acc_any   = 1'b0;
    acc_bad   = 1'b0;
    acc_ovf   = 1'b0;
  endtask

  // One character into the whole or fraction accumulator
  task automatic absorb_char(input logic [7:0] c);
    bit         is_digit;
    logic [3:0] d;
    is_digit = (c >= dap_pkg::CH_ZERO) && (c <= dap_pkg::CH_NINE);
    d        = is_digit ? 4'(c - dap_pkg::CH_ZERO) : 4'd0;
    acc_any  = 1'b1;
    if (!acc_dot) begin
      if (c == dap_pkg::CH_DOT) begin
        acc_dot = 1'b1;
      end else if (!is_digit) begin
        acc_bad = 1'b1;
      end else if (!acc_ovf) begin
        // stop at the first digit that would leave 64 bits
        if (acc_whole > dap_pkg::WHOLE_LIM ||
            (acc_whole == dap_pkg::WHOLE_LIM && d > dap_pkg::WHOLE_LAST)) begin
          acc_ovf = 1'b1;
        end else begin
          acc_whole = acc_whole * 64'd10 + 64'(d);
        end
      end
    end else begin
      // every character after the first dot counts, a second dot too
      if (acc_flen < dap_pkg::FLEN_SAT) acc_flen = acc_flen + 5'd1;
      if (!is_digit) begin
        acc_bad = 1'b1;
      end else if (acc_flen <= MAX_FRAC_DIGITS) begin
        acc_frac = acc_frac * 64'd10 + 64'(d);
      end
    end
  endtask

  // Status and atoms at the end of an amount
  function automatic dap_pkg::result_t settle_amount();
    int               dec;
    logic [127:0]     prod;
    logic [63:0]      fval;
    logic [63:0]      sum;
    logic             carry;
    dap_pkg::result_t r;
    dec     = (cfg_decimals > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(cfg_decimals);
    r.atoms  = '0;
    r.status = dap_pkg::ST_OK;
    if (!acc_any) begin
      r.status = dap_pkg::ST_EMPTY;
    end else if (acc_flen > dec) begin
      r.status = dap_pkg::ST_DECIMALS;
    end else if (acc_bad) begin
      r.status = dap_pkg::ST_INVALID;
    end else if (acc_ovf) begin
      r.status = dap_pkg::ST_OVERFLOW;
    end else begin
      prod = {64'd0, acc_whole} * {64'd0, cfg_scale};
      if (prod[127:64] != '0 || prod[63:0] > cfg_supply) begin
        r.status = dap_pkg::ST_SUPPLY;
      end else begin
        fval = acc_frac * ten_to(dec - int'(acc_flen));
        {carry, sum} = {1'b0, prod[63:0]} + {1'b0, fval};
        if (carry) begin
          r.status = dap_pkg::ST_OVERFLOW;
        end else if (sum > cfg_supply) begin
          r.status = dap_pkg::ST_SUPPLY;
        end else begin
          r.atoms = sum;
        end
      end
    end
    return r;
  endfunction

  task automatic track_item(input dap_pkg::in_item_t it);
    if (it.has_char) absorb_char(it.char_code);
    if (it.last) begin
      expected_amounts.push_back(settle_amount());
      clear_amount();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop pacing and checking
  // ---------------------------------------------------------------------------

  initial begin : pop_pacing
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        // long hold-off so the block backs up into its input
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        pop <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    dap_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_amounts.size() == 0) begin
        $display("%0t: result with none expected, status %0d atoms %0d",
                 $time, result_o.status, result_o.atoms);
        err_count++;
      end else begin
        want = expected_amounts.pop_front();
        if (result_o.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, result_o.status);
          err_count++;
        end
        if (result_o.atoms !== want.atoms) begin
          $display("%0t: atoms mismatch, expected %0d actual %0d",
                   $time, want.atoms, result_o.atoms);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item, wait until taken, then maybe leave a gap
  task automatic send_item(input logic hc, input logic [7:0] ch, input logic lst);
    dap_pkg::in_item_t it;
    int                n;
    it.has_char  = hc;
    it.char_code = ch;
    it.last      = lst;
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    track_item(it);
    if (hc || lst) items_sent++;
    if (tx_gap_rate != 0 && $urandom_range(0, tx_gap_rate - 1) == 0) begin
      n = $urandom_range(1, 10);
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Characters of one amount; end on the last character or by a bare end marker
  task automatic send_chars(input logic [7:0] txt[$], input bit sep_end);
    int i;
    for (i = 0; i < txt.size(); i++) begin
      if (noise_rate != 0 && $urandom_range(0, noise_rate - 1) == 0) begin
        send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      end
      send_item(1'b1, txt[i], !sep_end && (i == txt.size() - 1));
    end
    if (sep_end || txt.size() == 0) begin
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic send_amount(input string s, input bit sep_end);
    logic [7:0] txt[$];
    int         i;
    for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_chars(txt, sep_end);
  endtask

  // Mostly well-formed amounts with random content, some broken
  task automatic send_random_amount();
    logic [7:0] txt[$];
    string      lim;
    int         dec, nw, nf, sel, i;
    dec = (cfg_decimals > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(cfg_decimals);
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      // whole part right at the 64-bit boundary
      lim = "1844674407370955161";
      for (i = 0; i < lim.len(); i++) txt.push_back(lim[i]);
      txt.push_back(8'(dap_pkg::CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
        txt.push_back(8'(dap_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
    end else begin
      nw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 22) : $urandom_range(0, 6);
      repeat (nw) txt.push_back(8'(dap_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) != 0) begin
      txt.push_back(dap_pkg::CH_DOT);
      nf = ($urandom_range(0, 7) == 0) ? dec + $urandom_range(1, 3) : $urandom_range(0, dec);
      repeat (nf) txt.push_back(8'(dap_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    // corruption: a random byte or a stray dot
    sel = $urandom_range(0, 9);
    if (sel == 0 && txt.size() > 0) begin
      txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (sel == 1) begin
      txt.insert($urandom_range(0, txt.size()), dap_pkg::CH_DOT);
    end
    send_chars(txt, $urandom_range(0, 3) == 0);
  endtask

  // Stop offering and wait for every pending result, then let the pipe settle
  task automatic drain_results();
    push <= 1'b0;
    while (expected_amounts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; valid stays high for a following write
  task automatic put_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      dap_pkg::CFG_DECIMALS:   cfg_decimals = data[4:0];
      dap_pkg::CFG_ATOM_SCALE: cfg_scale    = data;
      dap_pkg::CFG_SUPPLY:     cfg_supply   = data;
      default: ;
    endcase
  endtask

  // Write all registers; the block must be idle
  task automatic write_regs(input logic [4:0] dec, input logic [63:0] scale,
                            input logic [63:0] supply, input bit spare);
    logic [63:0] dec_word;
    dec_word      = {$urandom, $urandom};
    dec_word[4:0] = dec;
    put_reg(dap_pkg::CFG_DECIMALS, dec_word);
    put_reg(dap_pkg::CFG_ATOM_SCALE, scale);
    put_reg(dap_pkg::CFG_SUPPLY, supply);
    if (spare) put_reg(CFG_SPARE, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [4:0] dec, input logic [63:0] scale,
                           input logic [63:0] supply, input int tx_rate,
                           input bit rx_on, input int count, input bit spare);
    int stop_at;
    drain_results();
    write_regs(dec, scale, supply, spare);
    tx_gap_rate = tx_rate;
    rx_stall_en = rx_on;
    noise_rate  = 20;
    stop_at     = items_sent + count;
    while (items_sent < stop_at) send_random_amount();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: empty amount, leading dot, second dot, byte extremes
  task automatic test_basic_chars();
    tx_gap_rate = 3;
    rx_stall_en = 1'b1;
    send_item(1'b0, 8'hff, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    send_amount(".5", 1'b0);
    send_amount("1..", 1'b0);
    send_item(1'b1, 8'h00, 1'b1);
    send_item(1'b1, 8'hff, 1'b1);
    send_amount("2", 1'b1);
  endtask

  // Too many decimals, supply limits, zero scale, clamped decimals, overflows
  task automatic test_register_corners();
    drain_results();
    write_regs(5'd2, 64'd100, 64'd1000, 1'b0);
    send_amount("0.123", 1'b0);
    send_amount("11", 1'b0);
    send_amount("10", 1'b0);
    drain_results();
    write_regs(5'd31, 64'd0, ALL_ONES, 1'b1);
    send_amount("5.1", 1'b0);
    drain_results();
    write_regs(5'd1, ALL_ONES, ALL_ONES, 1'b0);
    send_amount("1.5", 1'b0);
    drain_results();
    write_regs(5'd0, 64'd1, ALL_ONES, 1'b0);
    send_amount("18446744073709551616", 1'b0);
  endtask

  // Results pile up behind a long pop hold-off until the input stalls
  task automatic test_input_stall();
    drain_results();
    tx_gap_rate  = 0;
    noise_rate   = 0;
    hold_request = 1'b1;
    repeat (40) send_item(1'b1, 8'(dap_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b1);
    drain_results();
  endtask

  task automatic test_random_mix();
    int k;
    run_phase(dap_pkg::DECIMALS_RST, dap_pkg::ATOM_SCALE_RST, dap_pkg::SUPPLY_RST,
              6, 1'b1, 200, 1'b0);
    run_phase(5'd0, 64'd1, ALL_ONES, 8, 1'b1, 200, 1'b0);
    run_phase(5'd19, ten_to(19), ALL_ONES, 0, 1'b1, 200, 1'b0);
    run_phase(5'd2, 64'd100, 64'($urandom_range(1000, 1 << 24)), 5, 1'b0, 200, 1'b0);
    k = $urandom_range(0, 19);
    run_phase(5'd31, ten_to(k), {$urandom, $urandom}, 8, 1'b1, 200, 1'b1);
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady_stream();
    int k;
    k = $urandom_range(0, 19);
    run_phase(5'(k), ten_to(k), {$urandom, $urandom} >> $urandom_range(0, 40),
              0, 1'b0, 200, 1'b0);
  endtask

  initial begin
    cfg_decimals = dap_pkg::DECIMALS_RST;
    cfg_scale    = dap_pkg::ATOM_SCALE_RST;
    cfg_supply   = dap_pkg::SUPPLY_RST;
    clear_amount();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_chars();
    test_register_corners();
    test_input_stall();
    test_random_mix();
    test_steady_stream();
    drain_results();
    if (expected_amounts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_amounts.size());
    end
    if (err_count == 0 && expected_amounts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[decimal_amount_parser.f]
sv/dap_pkg.sv
sv/dap_fifo.sv
sv/dap_front.sv
sv/dap_back.sv
sv/decimal_amount_parser.sv
tb/tb_decimal_amount_parser.sv
